@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is not evaluated while the active-low reset is low.
`define HPC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Concurrent assertion that is evaluated on every rising clock edge, reset included.
`define HPC_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/hpc_pkg.sv @@
// Shared widths, register indexes, state type and saturating increment helper of the histogram clip unit.
package hpc_pkg;

    // Field and register widths.
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CUT_W     = 16;
    localparam int CNT_W     = 21;
    localparam int OUT_BIN_W = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_FRACTION = 2'd3;

    // Saturation limit of every counter.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_NPIX,
        ST_NCUT,
        ST_WALK,
        ST_EMIT,
        ST_CLEAR
    } t_state;

    // Increment that sticks at the counter maximum.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

endpackage

@@ rtl/core/hpc_bin_ram.sv @@
// Bin count memory: one write port and two registered read ports.
module hpc_bin_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 21
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

@@ rtl/core/histogram_percentile_clip_unit.sv @@
// Histogram percentile clip unit: top level with sequencer, bin divider and trim walk.
//
// Usage: samples arrive on the s_axis channel, one per transfer, with tlast on the
// final sample of a data set. Each defined in-range sample is counted into one of NUM_BINS
// bins, bin zero in a register and the rest in an internal memory (read, increment, write
// back). On the transfer that carries tlast the unit trims the histogram from both ends and
// sends one m_axis transfer with the lower and upper clip bins, then clears the histogram.
// Steps: a sample counted above bin zero passes classification, the range check, the bin
// divider (one quotient bit per cycle) and then the memory read and write back; one counted
// in bin zero skips the write back, and the divider too when its scaled offset is negative.
// An undefined sample or one with an empty range ends after classification, one outside
// the range after the check. After the last sample the unit works out the pixel and cut
// counts, the trim walk drops bins one at a time (at most NUM_BINS - 2), and the result
// is loaded, then a clearing sweep zeroes every bin. Reset clears all counters and starts
// the same clearing sweep of the memory; s_axis_tready stays low until it is done. The
// configuration port is taken at any time but is meant to be written between data sets.
// A stalled receiver holds the result in the output register; the unit keeps taking
// samples and only waits when a second result is ready before the first is taken.
module histogram_percentile_clip_unit #(
    parameter int NUM_BINS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample channel.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hpc_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] sample
    input  logic                              s_axis_tlast,   // last_item
    // Result channel.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*hpc_pkg::OUT_BIN_W-1:0]   m_axis_tdata,   // [7:0] low_bin, [15:8] high_bin
    // Configuration write port.
    input  logic                              i_cfg_wr_en,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [hpc_pkg::CFG_W-1:0]         i_cfg_wr_data
);

    import hpc_pkg::*;

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int NUM_W  = SAMPLE_W + BIN_W + 2;
    localparam int DIV_W  = SAMPLE_W + BIN_W;
    localparam int STEP_W = $clog2(BIN_W);
    localparam int NPIX_W = CNT_W + 2;
    localparam int DROP_W = CNT_W + 1;
    localparam int PROD_W = CNT_W + CUT_W;

    localparam logic [BIN_W-1:0]        BIN_FIRST = BIN_W'(1);
    localparam logic [BIN_W-1:0]        BIN_LAST  = BIN_W'(NUM_BINS - 1);
    localparam logic [STEP_W-1:0]       STEP_LAST = STEP_W'(BIN_W - 1);
    localparam logic signed [NUM_W-1:0] SCALE     = NUM_W'(NUM_BINS - 1);
    localparam logic [NUM_W-1:0]        BIN_COUNT = NUM_W'(NUM_BINS);

    // Configuration registers.
    logic signed [CFG_W-1:0] r_undef_code;
    logic signed [CFG_W-1:0] r_range_low;
    logic signed [CFG_W-1:0] r_range_high;
    logic [CUT_W-1:0]        r_cut;

    // Sequencer and datapath registers.
    t_state                  r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic                    r_last, n_last;
    logic                    r_skip, n_skip;
    logic [CNT_W-1:0]        r_total, n_total;
    logic [CNT_W-1:0]        r_undef, n_undef;
    logic [CNT_W-1:0]        r_zero, n_zero;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [CFG_W-1:0]        r_den, n_den;
    logic [NUM_W-1:0]        r_lim, n_lim;
    logic [DIV_W-1:0]        r_rem, n_rem;
    logic [DIV_W-1:0]        r_dsr, n_dsr;
    logic [BIN_W-1:0]        r_q, n_q;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [CNT_W-1:0]        r_npix, n_npix;
    logic [CNT_W-1:0]        r_ncut, n_ncut;
    logic [DROP_W-1:0]       r_drop, n_drop;
    logic [BIN_W-1:0]        r_a, n_a;
    logic [BIN_W-1:0]        r_z, n_z;
    logic [BIN_W-1:0]        r_clr, n_clr;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_BIN_W-1:0]    r_out_low, n_out_low;
    logic [OUT_BIN_W-1:0]    r_out_high, n_out_high;

    // Memory port signals.
    logic                    mem_wr_en;
    logic [BIN_W-1:0]        mem_wr_addr;
    logic [CNT_W-1:0]        mem_wr_data;
    logic [BIN_W-1:0]        mem_rd_addr_a;
    logic [BIN_W-1:0]        mem_rd_addr_b;
    logic [CNT_W-1:0]        mem_rd_data_a;
    logic [CNT_W-1:0]        mem_rd_data_b;

    // Combinational helpers.
    logic                    s_accept;
    logic                    slot_free;
    logic                    hi_gt_lo;
    logic                    is_undef;
    logic                    num_neg;
    logic                    in_zero;
    logic                    in_range;
    logic                    walk_go;
    logic                    take_a;
    logic signed [SAMPLE_W:0] diff_s;
    logic signed [SAMPLE_W:0] diff_hl;
    logic signed [NUM_W-1:0]  diff_ext;
    logic [NUM_W-1:0]        neg_mag;
    logic [NUM_W-1:0]        den_ext;
    logic signed [NPIX_W-1:0] npix_s;
    logic [PROD_W-1:0]       cut_prod;
    t_state                  after_count;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_high, r_out_low};

    // Sample classification arithmetic.
    assign hi_gt_lo = (r_range_high > r_range_low);
    assign is_undef = (s_axis_tdata == $unsigned(r_undef_code));
    assign diff_s   = {r_sample[SAMPLE_W-1], r_sample} - {r_range_low[CFG_W-1], r_range_low};
    assign diff_hl  = {r_range_high[CFG_W-1], r_range_high}
                    - {r_range_low[CFG_W-1], r_range_low};
    assign diff_ext = NUM_W'(diff_s);
    assign num_neg  = r_num[NUM_W-1];
    assign neg_mag  = NUM_W'(-r_num);
    assign den_ext  = NUM_W'(r_den);
    assign in_zero  = (neg_mag < den_ext);
    assign in_range = ($unsigned(r_num) < r_lim);

    // Trim arithmetic.
    assign npix_s   = $signed({2'b00, r_total}) - $signed({2'b00, r_undef})
                    - $signed({2'b00, r_zero});
    assign cut_prod = PROD_W'(r_npix) * PROD_W'(r_cut);
    assign walk_go  = ({1'b0, r_ncut} > r_drop) && (r_a < r_z);
    assign take_a   = (mem_rd_data_a < mem_rd_data_b);

    assign after_count = r_last ? ST_NPIX : ST_IDLE;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undef_code <= 16'sh8000;
            r_range_low  <= 16'sd0;
            r_range_high <= 16'sd255;
            r_cut        <= 16'd655;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_UNDEF_CODE:   r_undef_code <= $signed(i_cfg_wr_data);
                CFG_RANGE_LOW:    r_range_low  <= $signed(i_cfg_wr_data);
                CFG_RANGE_HIGH:   r_range_high <= $signed(i_cfg_wr_data);
                CFG_CUT_FRACTION: r_cut        <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                n_state = r_skip ? after_count : ST_CHECK;
            end
            ST_CHECK: begin
                if (num_neg) begin
                    n_state = in_zero ? ST_READ : after_count;
                end else begin
                    n_state = in_range ? ST_DIV : after_count;
                end
            end
            ST_DIV: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = (r_q == '0) ? after_count : ST_WRITE;
            end
            ST_WRITE: n_state = after_count;
            ST_NPIX:  n_state = ST_NCUT;
            ST_NCUT:  n_state = ST_WALK;
            ST_WALK: begin
                if (!walk_go) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (r_clr == BIN_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath next values and memory controls.
    always_comb begin
        n_sample      = r_sample;
        n_last        = r_last;
        n_skip        = r_skip;
        n_total       = r_total;
        n_undef       = r_undef;
        n_zero        = r_zero;
        n_num         = r_num;
        n_den         = r_den;
        n_lim         = r_lim;
        n_rem         = r_rem;
        n_dsr         = r_dsr;
        n_q           = r_q;
        n_step        = r_step;
        n_npix        = r_npix;
        n_ncut        = r_ncut;
        n_drop        = r_drop;
        n_a           = r_a;
        n_z           = r_z;
        n_clr         = r_clr;
        n_out_low     = r_out_low;
        n_out_high    = r_out_high;
        n_out_valid   = r_out_valid && !m_axis_tready;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_q;
        mem_wr_data   = sat_inc(mem_rd_data_a);
        mem_rd_addr_a = r_a;
        mem_rd_addr_b = r_z;
        case (r_state)
            ST_IDLE: begin
                // Take the sample, count it in the total and, if it is undefined, as undefined.
                if (s_accept) begin
                    n_sample = $signed(s_axis_tdata);
                    n_last   = s_axis_tlast;
                    n_total  = sat_inc(r_total);
                    n_skip   = is_undef || !hi_gt_lo;
                    if (is_undef) begin
                        n_undef = sat_inc(r_undef);
                    end
                end
            end
            ST_CLASS: begin
                // Scaled offset, range width and upper bound of the bin numerator.
                n_num = NUM_W'(diff_ext * SCALE);
                n_den = CFG_W'(diff_hl);
                n_lim = NUM_W'($unsigned(CFG_W'(diff_hl))) * BIN_COUNT;
            end
            ST_CHECK: begin
                // A small negative numerator truncates to bin zero.
                n_q    = '0;
                n_step = '0;
                n_rem  = DIV_W'(r_num);
                n_dsr  = DIV_W'(r_den) << (BIN_W - 1);
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (r_rem >= r_dsr) begin
                    n_rem = r_rem - r_dsr;
                    n_q   = {r_q[BIN_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[BIN_W-2:0], 1'b0};
                end
                n_dsr  = r_dsr >> 1;
                n_step = r_step + STEP_W'(1);
            end
            ST_READ: begin
                // Bin zero lives in a register; other bins are read from memory.
                mem_rd_addr_a = r_q;
                if (r_q == '0) begin
                    n_zero = sat_inc(r_zero);
                end
            end
            ST_WRITE: begin
                mem_wr_en = 1'b1;
            end
            ST_NPIX: begin
                n_npix = npix_s[NPIX_W-1] ? '0 : CNT_W'(npix_s);
                n_a    = BIN_FIRST;
                n_z    = BIN_LAST;
            end
            ST_NCUT: begin
                n_ncut = cut_prod[PROD_W-1:CUT_W];
                n_drop = '0;
            end
            ST_WALK: begin
                // Drop the smaller end; a tie drops the top end.
                if (walk_go) begin
                    if (take_a) begin
                        n_drop = r_drop + DROP_W'(mem_rd_data_a);
                        n_a    = r_a + BIN_W'(1);
                    end else begin
                        n_drop = r_drop + DROP_W'(mem_rd_data_b);
                        n_z    = r_z - BIN_W'(1);
                    end
                end
                mem_rd_addr_a = n_a;
                mem_rd_addr_b = n_z;
            end
            ST_EMIT: begin
                // Load the result once the output register is free.
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_low   = OUT_BIN_W'(r_a);
                    n_out_high  = OUT_BIN_W'(r_z);
                    n_total     = '0;
                    n_undef     = '0;
                    n_zero      = '0;
                    n_clr       = '0;
                end
            end
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr;
                mem_wr_data = '0;
                n_clr       = r_clr + BIN_W'(1);
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_total     <= '0;
            r_undef     <= '0;
            r_zero      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_total     <= n_total;
            r_undef     <= n_undef;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_last     <= n_last;
        r_skip     <= n_skip;
        r_num      <= n_num;
        r_den      <= n_den;
        r_lim      <= n_lim;
        r_rem      <= n_rem;
        r_dsr      <= n_dsr;
        r_q        <= n_q;
        r_step     <= n_step;
        r_npix     <= n_npix;
        r_ncut     <= n_ncut;
        r_drop     <= n_drop;
        r_a        <= n_a;
        r_z        <= n_z;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
    end

    // Bin counts; a read whose data is used never overlaps a write.
    hpc_bin_ram #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (BIN_W),
        .DATA_W (CNT_W)
    ) u_bin_ram (
        .i_clk       (i_clk),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (mem_wr_data),
        .i_rd_addr_a (mem_rd_addr_a),
        .i_rd_addr_b (mem_rd_addr_b),
        .o_rd_data_a (mem_rd_data_a),
        .o_rd_data_b (mem_rd_data_b)
    );

endmodule

@@ rtl/core/hpc_checker.sv @@
// Port-level checker of the histogram clip unit and its bind statement.
`include "assert_macros.svh"

module hpc_checker #(
    parameter int NUM_BINS = 256
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [2*hpc_pkg::OUT_BIN_W-1:0]   m_axis_tdata
);

    import hpc_pkg::*;

    logic [OUT_BIN_W-1:0] low_bin;
    logic [OUT_BIN_W-1:0] high_bin;

    assign low_bin  = m_axis_tdata[OUT_BIN_W-1:0];
    assign high_bin = m_axis_tdata[2*OUT_BIN_W-1:OUT_BIN_W];

    // A stalled result stays valid and unchanged.
    `HPC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Reset empties the output register.
    `HPC_ASSERT(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // The unit is busy in the cycle after each sample transfer.
    `HPC_ASSERT_RST(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "sample taken in back-to-back cycles")

    // Trim limits are ordered and never below bin one.
    `HPC_ASSERT_RST(a_bins_ordered, i_clk, i_rst_n, m_axis_tvalid |-> (NUM_BINS > 256) || (low_bin != '0 && low_bin <= high_bin), "clip bins out of order")

endmodule

bind histogram_percentile_clip_unit hpc_checker #(
    .NUM_BINS (NUM_BINS)
) u_hpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/histogram_percentile_clip_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the histogram percentile clip unit, with its own histogram mirror.
module histogram_percentile_clip_unit_tb;

    localparam int NUM_BINS     = 256;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 640;
    localparam int HOLD_CYCLES  = 3000;
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        logic        last;
        logic [15:0] sample;
    } t_sample_item;

    typedef struct packed {
        logic [7:0] high_bin;
        logic [7:0] low_bin;
    } t_clip_pair;

    // Block ports; the inputs driven here are known from time zero.
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [hpc_pkg::SAMPLE_W-1:0]        s_axis_tdata  = '0;   // [15:0] sample
    logic                                s_axis_tlast  = 1'b0; // last_item
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [2*hpc_pkg::OUT_BIN_W-1:0]     m_axis_tdata;         // [7:0] low_bin, [15:8] high_bin
    logic                                i_cfg_wr_en   = 1'b0;
    logic [hpc_pkg::CFG_IDX_W-1:0]       i_cfg_addr    = '0;
    logic [hpc_pkg::CFG_W-1:0]           i_cfg_wr_data = '0;

    // Mirror of the configuration registers, starting from their reset values.
    logic signed [15:0] cfg_undef = -16'sd32768;
    logic signed [15:0] cfg_low   = 16'sd0;
    logic signed [15:0] cfg_high  = 16'sd255;
    logic        [15:0] cfg_cut   = 16'd655;

    // Mirror of the histogram store.
    logic [20:0] hist_bins [NUM_BINS];
    logic [20:0] undef_tally;
    logic [20:0] total_tally;

    t_sample_item sample_q[$];
    t_clip_pair   expected_clips[$];
    t_clip_pair   got_clip;
    t_clip_pair   want_clip;
    t_sample_item next_item;

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_seq      = 0;
    int    hold_seen     = 0;
    int    hold_left     = 0;
    int    err_count     = 0;
    int    cycle_count   = 0;
    int    random_items  = 0;
    int    phase;
    int    set_idx;
    int    set_count;
    logic  in_taken      = 1'b0;

    histogram_percentile_clip_unit #(
        .NUM_BINS(NUM_BINS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // Clock generation.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Counter increment that sticks at the 21-bit maximum.
    function automatic logic [20:0] count_up(input logic [20:0] c);
        return (c == {21{1'b1}}) ? c : c + 21'd1;
    endfunction

    task automatic clear_tallies();
        foreach (hist_bins[i]) hist_bins[i] = '0;
        undef_tally = '0;
        total_tally = '0;
    endtask

    // Counts one accepted sample; on the last one of a set, predicts the clip bins.
    task automatic tally_sample(input logic signed [15:0] s, input logic last);
        longint     num;
        longint     bin;
        longint     npix;
        longint     ncut;
        longint     dropped;
        int         lo_end;
        int         hi_end;
        t_clip_pair clip;
        total_tally = count_up(total_tally);
        if (s == cfg_undef) begin
            undef_tally = count_up(undef_tally);
        end else if (cfg_high > cfg_low) begin
            num = (longint'(s) - longint'(cfg_low)) * (NUM_BINS - 1);
            bin = num / (longint'(cfg_high) - longint'(cfg_low));
            if (bin >= 0 && bin < NUM_BINS) begin
                hist_bins[bin] = count_up(hist_bins[bin]);
            end
        end
        if (last) begin
            npix = longint'(total_tally) - longint'(undef_tally) - longint'(hist_bins[0]);
            if (npix < 0) npix = 0;
            ncut = (npix * longint'(cfg_cut)) >> 16;
            dropped = 0;
            lo_end = 1;
            hi_end = NUM_BINS - 1;
            // Trim the smaller end first; a tie trims the top end.
            while (dropped < ncut && lo_end < hi_end) begin
                if (hist_bins[lo_end] < hist_bins[hi_end]) begin
                    dropped += hist_bins[lo_end];
                    lo_end++;
                end else begin
                    dropped += hist_bins[hi_end];
                    hi_end--;
                end
            end
            clip.low_bin  = 8'(lo_end);
            clip.high_bin = 8'(hi_end);
            expected_clips = {expected_clips, clip};
            clear_tallies();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // One register write, mirrored at the same time; only used while the block is idle.
    task automatic write_reg(input logic [hpc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= val;
        case (idx)
            hpc_pkg::CFG_UNDEF_CODE:   cfg_undef = val;
            hpc_pkg::CFG_RANGE_LOW:    cfg_low   = val;
            hpc_pkg::CFG_RANGE_HIGH:   cfg_high  = val;
            hpc_pkg::CFG_CUT_FRACTION: cfg_cut   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic push_item(input int v, input logic last);
        t_sample_item item;
        item.sample = 16'(v);
        item.last   = last;
        sample_q = {sample_q, item};
    endtask

    // Queues one data set; most samples land near the configured range.
    task automatic push_set(input int n);
        int v;
        int lo;
        int hi;
        lo = cfg_low;
        hi = cfg_high;
        if (hi < lo) hi = lo;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: v = cfg_undef;
                1: begin
                    case ($urandom_range(0, 3))
                        0: v = -32768;
                        1: v = 32767;
                        2: v = 0;
                        default: v = -1;
                    endcase
                end
                2: v = int'($urandom_range(0, 65535)) - 32768;
                default: v = lo - 20 + int'($urandom_range(0, hi - lo + 40));
            endcase
            if (v < -32768) v = -32768;
            if (v > 32767) v = 32767;
            push_item(v, k == n - 1);
        end
        random_items += n;
    endtask

    // Picks a new register setting, extremes included, and writes every register.
    task automatic pick_config();
        int lo;
        int hi;
        int span;
        int undef_v;
        int cut_v;
        case ($urandom_range(0, 5))
            0: begin
                lo = -32768;
                hi = 32767;
            end
            1: begin
                lo = 0;
                hi = 255;
            end
            2: begin
                // Empty range, equal ends included.
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = lo - int'($urandom_range(0, 300));
                if (hi < -32768) hi = -32768;
            end
            5: begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = int'($urandom_range(0, 65535)) - 32768;
            end
            default: begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                span = $urandom_range(1, 600);
                hi = lo + span;
                if (hi > 32767) begin
                    hi = 32767;
                    lo = hi - span;
                end
            end
        endcase
        case ($urandom_range(0, 3))
            0: undef_v = -32768;
            1: undef_v = 32767;
            2: undef_v = lo + int'($urandom_range(0, (hi > lo) ? hi - lo : 0));
            default: undef_v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        case ($urandom_range(0, 4))
            0: cut_v = 0;
            1: cut_v = 65535;
            2: cut_v = 655;
            3: cut_v = $urandom_range(1, 4000);
            default: cut_v = $urandom_range(0, 65535);
        endcase
        write_reg(hpc_pkg::CFG_UNDEF_CODE, 16'(undef_v));
        write_reg(hpc_pkg::CFG_RANGE_LOW, 16'(lo));
        write_reg(hpc_pkg::CFG_RANGE_HIGH, 16'(hi));
        write_reg(hpc_pkg::CFG_CUT_FRACTION, 16'(cut_v));
    endtask

    // Waits until every queued sample is taken and every clip pair has come,
    // then lets the trim walk and the clearing sweep finish.
    task automatic drain_results();
        while (sample_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_clips.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Sample driver: presents a new transfer once the previous one was taken.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_item = sample_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.sample;
                s_axis_tlast  <= next_item.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: mirrors accepted samples and checks each result transfer in order.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                tally_sample(s_axis_tdata, s_axis_tlast);
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_clip = m_axis_tdata;
                if (expected_clips.size() == 0) begin
                    report_mismatch("unexpected clip transfer, tdata", m_axis_tdata, -1);
                end else begin
                    want_clip = expected_clips.pop_front();
                    if (got_clip.low_bin !== want_clip.low_bin) begin
                        report_mismatch("low_bin", got_clip.low_bin, want_clip.low_bin);
                    end
                    if (got_clip.high_bin !== want_clip.high_bin) begin
                        report_mismatch("high_bin", got_clip.high_bin, want_clip.high_bin);
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        clear_tallies();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: range ends, undefined code, out-of-range values, nothing to trim.
        push_item(0, 1'b0);
        push_item(255, 1'b0);
        push_item(1, 1'b0);
        push_item(128, 1'b0);
        push_item(-32768, 1'b0);
        push_item(256, 1'b0);
        push_item(-1, 1'b0);
        push_item(32767, 1'b1);
        drain_results();

        // Full 16-bit range with the largest cut fraction.
        write_reg(hpc_pkg::CFG_UNDEF_CODE, 16'h7FFF);
        write_reg(hpc_pkg::CFG_RANGE_LOW, 16'h8000);
        write_reg(hpc_pkg::CFG_RANGE_HIGH, 16'h7FFF);
        write_reg(hpc_pkg::CFG_CUT_FRACTION, 16'hFFFF);
        push_item(-32768, 1'b0);
        push_item(32767, 1'b0);
        push_item(-1, 1'b0);
        push_item(0, 1'b0);
        push_item(16384, 1'b0);
        push_item(-16384, 1'b0);
        push_item(100, 1'b1);
        drain_results();

        // Equal counts at both ends, where the top end goes first.
        write_reg(hpc_pkg::CFG_UNDEF_CODE, 16'h8000);
        write_reg(hpc_pkg::CFG_RANGE_LOW, 16'd0);
        write_reg(hpc_pkg::CFG_RANGE_HIGH, 16'd255);
        push_item(10, 1'b0);
        push_item(10, 1'b0);
        push_item(200, 1'b0);
        push_item(200, 1'b0);
        push_item(100, 1'b1);
        drain_results();

        // Empty range: nothing is binned.
        write_reg(hpc_pkg::CFG_RANGE_LOW, 16'd100);
        write_reg(hpc_pkg::CFG_RANGE_HIGH, 16'd100);
        write_reg(hpc_pkg::CFG_CUT_FRACTION, 16'h8000);
        push_item(100, 1'b0);
        push_item(5, 1'b0);
        push_item(-32768, 1'b0);
        push_item(200, 1'b1);
        drain_results();

        // Random data sets in three back-pressure phases.
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 7 : 0;
            if (phase == 2) begin
                // Long receiver stall while short sets keep coming, so the input backs up.
                hold_seq++;
                for (set_idx = 0; set_idx < 12; set_idx++) push_set($urandom_range(1, 3));
                drain_results();
            end
            while (random_items < (phase + 1) * RANDOM_ITEMS / 3) begin
                pick_config();
                set_count = $urandom_range(2, 6);
                for (set_idx = 0; set_idx < set_count; set_idx++) begin
                    if ($urandom_range(0, 99) < 15) begin
                        push_set($urandom_range(100, 160));
                    end else begin
                        push_set($urandom_range(1, 12));
                    end
                end
                drain_results();
            end
        end

        if (expected_clips.size() != 0) begin
            report_mismatch("clip pairs never sent", 0, expected_clips.size());
        end
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
